// ===== hdl/hcbp_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Huffman code bit packer package
// Shared types and constants for the packer, its result queue and its
// channel interfaces.
// ----------------------------------------------------------------------------
package hcbp_pkg;

   // Request function codes.
   typedef enum logic [1:0] {
      FUNC_LOAD   = 2'd0,
      FUNC_ENCODE = 2'd1,
      FUNC_FLUSH  = 2'd2
   } func_type;

   // Fixed field widths of the channels.
   localparam int FUNC_W    = 2;
   localparam int SYMBOL_W  = 8;
   localparam int CVALUE_W  = 16;
   localparam int CLEN_W    = 5;
   localparam int BYTE_W    = 8;
   localparam int TOTAL_W   = 32;

   // Width of the pending bit count and of a combined bit count.
   localparam int PEND_W    = 3;
   localparam int NBITS_W   = 5;

   // Result queue sizing.
   localparam int RSP_DEPTH = 8;
   localparam int RSP_PTR_W = 3;
   localparam int RSP_FILL_W = 4;

   // One result item.
   typedef struct packed {
      logic [BYTE_W-1:0]  packed_byte;
      logic               byte_valid;
      logic               last;
      logic [TOTAL_W-1:0] total_bits;
   } rsp_type;

   // Results produced by one request, earliest first.
   typedef struct packed {
      logic [1:0] count;
      rsp_type    first;
      rsp_type    second;
   } push_type;

endpackage
`default_nettype wire

// ===== hdl/hcbp_req_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Request channel interface
// Valid/ready channel carrying one packer request.
// ----------------------------------------------------------------------------
interface hcbp_req_if;
   logic                          valid;
   logic                          ready;
   logic [hcbp_pkg::FUNC_W-1:0]   func;
   logic [hcbp_pkg::SYMBOL_W-1:0] symbol;
   logic [hcbp_pkg::CVALUE_W-1:0] code_value;
   logic [hcbp_pkg::CLEN_W-1:0]   code_length;

   modport source (output valid, func, symbol, code_value, code_length, input ready);
   modport sink   (input valid, func, symbol, code_value, code_length, output ready);
endinterface
`default_nettype wire

// ===== hdl/hcbp_rsp_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Result channel interface
// Valid/ready channel carrying one packed byte result.
// ----------------------------------------------------------------------------
interface hcbp_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [hcbp_pkg::BYTE_W-1:0]  packed_byte;
   logic                         byte_valid;
   logic                         last;
   logic [hcbp_pkg::TOTAL_W-1:0] total_bits;

   modport source (output valid, packed_byte, byte_valid, last, total_bits, input ready);
   modport sink   (input valid, packed_byte, byte_valid, last, total_bits, output ready);
endinterface
`default_nettype wire

// ===== hdl/hcbp_rsp_fifo.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Result queue
// Small queue that takes up to two results per cycle and presents one per
// cycle on the result channel while that channel is ready.
// ----------------------------------------------------------------------------
module hcbp_rsp_fifo (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire hcbp_pkg::push_type              push,
   output logic [hcbp_pkg::RSP_FILL_W-1:0]      fill,
   hcbp_rsp_if.source                           rsp_chan
);

   hcbp_pkg::rsp_type                       entry_ff [hcbp_pkg::RSP_DEPTH];
   logic [hcbp_pkg::RSP_PTR_W-1:0]          wr_ptr_ff, wr_ptr_in;
   logic [hcbp_pkg::RSP_PTR_W-1:0]          rd_ptr_ff, rd_ptr_in;
   logic [hcbp_pkg::RSP_FILL_W-1:0]         fill_ff, fill_in;
   logic [hcbp_pkg::RSP_PTR_W-1:0]          wr_ptr_next;
   logic                                    pop;

   // Head of the queue drives the result channel.
   assign rsp_chan.valid       = (fill_ff != '0);
   assign rsp_chan.packed_byte = entry_ff[rd_ptr_ff].packed_byte;
   assign rsp_chan.byte_valid  = entry_ff[rd_ptr_ff].byte_valid;
   assign rsp_chan.last        = entry_ff[rd_ptr_ff].last;
   assign rsp_chan.total_bits  = entry_ff[rd_ptr_ff].total_bits;
   assign pop                  = rsp_chan.valid && rsp_chan.ready;
   assign fill                 = fill_ff;
   assign wr_ptr_next          = wr_ptr_ff + hcbp_pkg::RSP_PTR_W'(1);

   // Pointer and fill level updates.
   always_comb begin
      wr_ptr_in = wr_ptr_ff + hcbp_pkg::RSP_PTR_W'(push.count);
      rd_ptr_in = pop ? rd_ptr_ff + hcbp_pkg::RSP_PTR_W'(1) : rd_ptr_ff;
      fill_in   = fill_ff + hcbp_pkg::RSP_FILL_W'(push.count)
                  - hcbp_pkg::RSP_FILL_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   // Entry storage; the second result goes into the slot after the first.
   always_ff @(posedge clock) begin
      if (push.count != 2'd0) begin
         entry_ff[wr_ptr_ff] <= push.first;
      end
      if (push.count == 2'd2) begin
         entry_ff[wr_ptr_next] <= push.second;
      end
   end

   // The queue never holds more than its depth.
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= hcbp_pkg::RSP_FILL_W'(hcbp_pkg::RSP_DEPTH))
      else $error("result queue overflow");

   // A result pushed into an empty queue is offered in the next cycle.
   a_empty_push: assert property (@(posedge clock) disable iff (reset)
      (fill_ff == '0 && push.count != 2'd0) |=> rsp_chan.valid)
      else $error("pushed result not offered");

   // Taking the only entry with nothing pushed empties the queue.
   a_drain: assert property (@(posedge clock) disable iff (reset)
      (pop && fill_ff == hcbp_pkg::RSP_FILL_W'(1) && push.count == 2'd0)
      |=> !rsp_chan.valid)
      else $error("queue not empty after last pop");

endmodule
`default_nettype wire

// ===== hdl/huffman_code_bit_packer.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Huffman code bit packer
// Byte-symbol Huffman encoder with a loadable code table and an 8-bit
// packer that emits whole bytes, MSB first.
// ----------------------------------------------------------------------------
// The block accepts one request per cycle while ready is high. A request
// passes through the table read stage (the code memory's single registered
// read port) and then the packing stage, after which its zero, one or two
// results sit in an eight-entry result queue and are offered from its head.
// Requests keep flowing while results wait; ready drops only when the queue
// could not hold the worst case of two results for the request in the read
// stage plus two for a new one, which happens when the result side takes
// fewer bytes than the codes produce (two-byte codes give two results each).
// A load followed directly by an encode of the same symbol sees the new
// entry. Encoding a symbol whose entry was never loaded gives undefined bytes
// and bit counts.
module huffman_code_bit_packer #(
   parameter int MAX_CODE_LEN = 16,
   parameter int SYMBOL_COUNT = 256
) (
   input  wire logic   clock,
   input  wire logic   reset,
   hcbp_req_if.sink    req_chan,
   hcbp_rsp_if.source  rsp_chan
);

   localparam int LEN_LIMIT = (MAX_CODE_LEN < hcbp_pkg::CVALUE_W) ?
                              MAX_CODE_LEN : hcbp_pkg::CVALUE_W;
   localparam int VAL_W     = LEN_LIMIT;
   localparam int LEN_W     = $clog2(LEN_LIMIT + 1);
   localparam int ENTRY_W   = VAL_W + LEN_W;
   localparam int IDX_W     = (SYMBOL_COUNT > 1) ? $clog2(SYMBOL_COUNT) : 1;
   localparam int WIDE_W    = hcbp_pkg::BYTE_W + VAL_W;
   localparam int NEED_W    = hcbp_pkg::RSP_FILL_W + 1;

   // Code table.
   logic [ENTRY_W-1:0]              code_mem [SYMBOL_COUNT];

   // Read stage registers.
   logic                            s1_valid_ff;
   hcbp_pkg::func_type              s1_func_ff;
   logic                            s1_in_range_ff;
   logic [ENTRY_W-1:0]              s1_entry_ff;

   // Packer state.
   logic [hcbp_pkg::BYTE_W-1:0]     acc_ff, acc_in;
   logic [hcbp_pkg::PEND_W-1:0]     pend_ff, pend_in;
   logic [hcbp_pkg::TOTAL_W-1:0]    total_ff, total_in;

   logic                            req_accept;
   hcbp_pkg::func_type              req_func;
   logic                            req_in_range;
   logic [IDX_W-1:0]                req_idx;
   logic [LEN_W-1:0]                load_len;
   logic [NEED_W-1:0]               need;
   logic [hcbp_pkg::RSP_FILL_W-1:0] fill;

   logic [hcbp_pkg::NBITS_W-1:0]    clen;
   logic [VAL_W-1:0]                cval;
   logic [VAL_W-1:0]                cmask;
   logic [WIDE_W-1:0]               wide;
   logic [WIDE_W-1:0]               shift_hi;
   logic [WIDE_W-1:0]               shift_lo;
   logic [hcbp_pkg::NBITS_W-1:0]    nbits;
   logic [hcbp_pkg::TOTAL_W:0]      total_sum;
   logic [hcbp_pkg::BYTE_W-1:0]     flush_byte;
   hcbp_pkg::push_type              push;

   // Request decode.
   assign req_accept   = req_chan.valid && req_chan.ready;
   assign req_func     = hcbp_pkg::func_type'(req_chan.func);
   assign req_in_range = ({24'd0, req_chan.symbol} < SYMBOL_COUNT);
   assign req_idx      = IDX_W'(req_chan.symbol);

   // Lengths above the limit are stored as the limit.
   always_comb begin
      if (req_chan.code_length > hcbp_pkg::CLEN_W'(LEN_LIMIT)) begin
         load_len = LEN_W'(LEN_LIMIT);
      end else begin
         load_len = LEN_W'(req_chan.code_length);
      end
   end

   // Accept only while the queue can take the worst case in flight.
   assign need = NEED_W'(fill) + (s1_valid_ff ? NEED_W'(2) : NEED_W'(0)) + NEED_W'(2);
   assign req_chan.ready = (need <= NEED_W'(hcbp_pkg::RSP_DEPTH));

   // Table write on load, registered table read on every request.
   always_ff @(posedge clock) begin
      if (req_accept && req_func == hcbp_pkg::FUNC_LOAD && req_in_range) begin
         code_mem[req_idx] <= {load_len, req_chan.code_value[VAL_W-1:0]};
      end
      if (req_accept) begin
         s1_entry_ff <= code_mem[req_idx];
      end
   end

   // Read stage control.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= req_accept;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_func_ff     <= req_func;
         s1_in_range_ff <= req_in_range;
      end
   end

   // Code fields from the table, with the length clamped once more.
   always_comb begin
      cval = s1_entry_ff[VAL_W-1:0];
      if (s1_entry_ff[ENTRY_W-1 -: LEN_W] > LEN_W'(LEN_LIMIT)) begin
         clen = hcbp_pkg::NBITS_W'(LEN_LIMIT);
      end else begin
         clen = hcbp_pkg::NBITS_W'(s1_entry_ff[ENTRY_W-1 -: LEN_W]);
      end
      cmask = ~({VAL_W{1'b1}} << clen);
   end

   // Append the code to the pending bits and cut out whole bytes.
   always_comb begin
      wide      = (WIDE_W'(acc_ff) << clen) | WIDE_W'(cval & cmask);
      nbits     = hcbp_pkg::NBITS_W'(pend_ff) + clen;
      shift_hi  = wide >> (nbits - hcbp_pkg::NBITS_W'(8));
      shift_lo  = wide >> (nbits - hcbp_pkg::NBITS_W'(16));
      total_sum = {1'b0, total_ff} + (hcbp_pkg::TOTAL_W + 1)'(clen);
      flush_byte = acc_ff << (hcbp_pkg::PEND_W + 1)'(4'd8 - {1'b0, pend_ff});
   end

   // Next state and results of the request in the packing stage.
   always_comb begin
      acc_in   = acc_ff;
      pend_in  = pend_ff;
      total_in = total_ff;
      push     = '0;
      if (s1_valid_ff) begin
         case (s1_func_ff)
            hcbp_pkg::FUNC_ENCODE: begin
               if (s1_in_range_ff) begin
                  pend_in  = nbits[hcbp_pkg::PEND_W-1:0];
                  acc_in   = wide[hcbp_pkg::BYTE_W-1:0]
                             & ~(8'hFF << nbits[hcbp_pkg::PEND_W-1:0]);
                  total_in = total_sum[hcbp_pkg::TOTAL_W] ?
                             '1 : total_sum[hcbp_pkg::TOTAL_W-1:0];
                  push.count              = nbits[4:3];
                  push.first.packed_byte  = shift_hi[hcbp_pkg::BYTE_W-1:0];
                  push.first.byte_valid   = 1'b1;
                  push.first.last         = 1'b0;
                  push.first.total_bits   = total_in;
                  push.second.packed_byte = shift_lo[hcbp_pkg::BYTE_W-1:0];
                  push.second.byte_valid  = 1'b1;
                  push.second.last        = 1'b0;
                  push.second.total_bits  = total_in;
               end
            end
            hcbp_pkg::FUNC_FLUSH: begin
               push.count             = 2'd1;
               push.first.packed_byte = flush_byte;
               push.first.byte_valid  = (pend_ff != '0);
               push.first.last        = 1'b1;
               push.first.total_bits  = total_ff;
               acc_in   = '0;
               pend_in  = '0;
               total_in = '0;
            end
            default: begin
               push = '0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff   <= '0;
         pend_ff  <= '0;
         total_ff <= '0;
      end else begin
         acc_ff   <= acc_in;
         pend_ff  <= pend_in;
         total_ff <= total_in;
      end
   end

   // Result queue.
   hcbp_rsp_fifo u_rsp_fifo (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .fill     (fill),
      .rsp_chan (rsp_chan)
   );

   // Bits above the pending count are always clear in the accumulator.
   a_acc_clean: assert property (@(posedge clock) disable iff (reset)
      (acc_ff >> pend_ff) == '0)
      else $error("stray bits in accumulator");

   // A flush leaves the packer empty with a cleared bit count.
   a_flush_clears: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && s1_func_ff == hcbp_pkg::FUNC_FLUSH)
      |=> (pend_ff == '0 && acc_ff == '0 && total_ff == '0))
      else $error("flush did not clear packer state");

   // A flush gives exactly one result, and it is marked last.
   a_flush_last: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && s1_func_ff == hcbp_pkg::FUNC_FLUSH)
      |-> (push.count == 2'd1 && push.first.last))
      else $error("flush result malformed");

   // A load never produces a result.
   a_load_silent: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && s1_func_ff == hcbp_pkg::FUNC_LOAD) |-> push.count == 2'd0)
      else $error("load produced a result");

endmodule
`default_nettype wire

// ===== tb/tb_huffman_code_bit_packer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Huffman code bit packer testbench
// Loads code table entries, encodes symbols and flushes through the request
// channel. A scoreboard class predicts every packed byte and final count, and
// each result is checked field by field. Both channels idle at random.
// ----------------------------------------------------------------------------
module tb_huffman_code_bit_packer;

   // The function code that the block ignores.
   localparam logic [1:0] FUNC_UNUSED = 2'd3;

   localparam int RANDOM_REQUESTS = 1200;
   localparam int QUIET_FROM      = 1000;
   localparam int DRAIN_EVERY     = 300;
   localparam int CYCLE_LIMIT     = 400000;

   // Scoreboard: a bit-level model of the packer and the bytes it owes.
   class byte_stream_checker;
      logic [15:0]       code_bits [256];
      logic [4:0]        code_len [256];
      logic [7:0]        accum;
      int                pending_bits;
      logic [31:0]       bit_count;
      hcbp_pkg::rsp_type expected_bytes [$];
      int                mismatches;

      function new();
         accum        = '0;
         pending_bits = 0;
         bit_count    = '0;
         mismatches   = 0;
         for (int i = 0; i < 256; i++) begin
            code_bits[i] = '0;
            code_len[i]  = '0;
         end
      endfunction

      function void push_byte(logic [7:0] data, logic data_valid, logic is_last);
         hcbp_pkg::rsp_type item;
         item.packed_byte = data;
         item.byte_valid  = data_valid;
         item.last        = is_last;
         item.total_bits  = bit_count;
         expected_bytes.push_back(item);
      endfunction

      // Update the model with one accepted request.
      function void note_request(logic [1:0] f, logic [7:0] sym, logic [15:0] value,
                                 logic [4:0] length);
         logic [32:0] sum;
         int          len;
         if (f == hcbp_pkg::FUNC_LOAD) begin
            // Lengths beyond sixteen bits are clipped; the value is kept as is.
            code_bits[sym] = value;
            code_len[sym]  = (length > 5'd16) ? 5'd16 : length;
         end else if (f == hcbp_pkg::FUNC_ENCODE) begin
            len = code_len[sym];
            if (len != 0) begin
               sum = {1'b0, bit_count} + 33'(len);
               bit_count = sum[32] ? '1 : sum[31:0];
               for (int i = len - 1; i >= 0; i--) begin
                  accum = {accum[6:0], code_bits[sym][i]};
                  pending_bits++;
                  if (pending_bits == 8) begin
                     push_byte(accum, 1'b1, 1'b0);
                     accum        = '0;
                     pending_bits = 0;
                  end
               end
            end
         end else if (f == hcbp_pkg::FUNC_FLUSH) begin
            // Pad a partial byte with zeros; an empty accumulator gives no data.
            if (pending_bits > 0)
               push_byte(accum << (8 - pending_bits), 1'b1, 1'b1);
            else
               push_byte(8'h00, 1'b0, 1'b1);
            accum        = '0;
            pending_bits = 0;
            bit_count    = '0;
         end
      endfunction

      task report_mismatch(string msg);
         $display("mismatch at %0t: %s", $realtime, msg);
         mismatches++;
      endtask

      // Compare one accepted result with the oldest expected one.
      task check_result(hcbp_pkg::rsp_type got);
         hcbp_pkg::rsp_type want;
         if (expected_bytes.size() == 0) begin
            report_mismatch($sformatf("unexpected result byte %02h valid %0b last %0b",
                                      got.packed_byte, got.byte_valid, got.last));
            return;
         end
         want = expected_bytes.pop_front();
         if (got.packed_byte !== want.packed_byte)
            report_mismatch($sformatf("packed_byte %02h, expected %02h",
                                      got.packed_byte, want.packed_byte));
         if (got.byte_valid !== want.byte_valid)
            report_mismatch($sformatf("byte_valid %0b, expected %0b",
                                      got.byte_valid, want.byte_valid));
         if (got.last !== want.last)
            report_mismatch($sformatf("last %0b, expected %0b", got.last, want.last));
         if (got.total_bits !== want.total_bits)
            report_mismatch($sformatf("total_bits %0d, expected %0d",
                                      got.total_bits, want.total_bits));
      endtask
   endclass

   logic clock;
   logic reset;

   hcbp_req_if req_chan ();
   hcbp_rsp_if rsp_chan ();

   huffman_code_bit_packer u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   byte_stream_checker board = new();

   bit                req_gaps_on;
   bit                rsp_stalls_on;
   bit                sym_loaded [256];
   logic [7:0]        loaded_syms [$];
   int                requests_done;
   int                cycle_count;
   hcbp_pkg::rsp_type got_byte;

   // Clock generation.
   initial clock = 1'b0;
   always #5 clock = ~clock;

   // Watchdog on the total run length.
   initial cycle_count = 0;
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("** huffman_code_bit_packer: FAILED **");
         $finish;
      end
   end

   // Result side: ready with random stall bursts.
   initial begin
      int stall_left;
      stall_left     = 0;
      rsp_chan.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (stall_left > 0) begin
            rsp_chan.ready <= 1'b0;
            stall_left--;
         end else begin
            rsp_chan.ready <= 1'b1;
            if (rsp_stalls_on && $urandom_range(0, 7) == 0)
               stall_left = $urandom_range(1, 11);
         end
      end
   end

   // Check every accepted result.
   always @(posedge clock) begin
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         got_byte.packed_byte = rsp_chan.packed_byte;
         got_byte.byte_valid  = rsp_chan.byte_valid;
         got_byte.last        = rsp_chan.last;
         got_byte.total_bits  = rsp_chan.total_bits;
         board.check_result(got_byte);
      end
   end

   // Drive one request, after an optional idle burst, and wait for acceptance.
   task automatic send_request(logic [1:0] f, logic [7:0] sym, logic [15:0] value,
                               logic [4:0] length);
      int gap;
      if (req_gaps_on && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 11);
         repeat (gap) begin
            @(negedge clock);
            req_chan.valid <= 1'b0;
         end
      end
      @(negedge clock);
      req_chan.valid       <= 1'b1;
      req_chan.func        <= f;
      req_chan.symbol      <= sym;
      req_chan.code_value  <= value;
      req_chan.code_length <= length;
      do @(posedge clock); while (!req_chan.ready);
      board.note_request(f, sym, value, length);
      if (f == hcbp_pkg::FUNC_LOAD && !sym_loaded[sym]) begin
         sym_loaded[sym] = 1'b1;
         loaded_syms.push_back(sym);
      end
   endtask

   // Hold off the sender until every owed result has come back.
   task automatic wait_for_drain();
      @(negedge clock);
      req_chan.valid <= 1'b0;
      while (board.expected_bytes.size() != 0)
         @(posedge clock);
   endtask

   // One random request; encodes only touch symbols already loaded.
   task automatic random_request();
      int          pick;
      int          lsel;
      logic [4:0]  length;
      logic [7:0]  sym;
      pick = $urandom_range(0, 99);
      if (loaded_syms.size() == 0 || pick < 15) begin
         lsel = $urandom_range(0, 19);
         if (lsel == 0)
            length = 5'd0;
         else if (lsel == 1)
            length = 5'($urandom_range(17, 31));
         else
            length = 5'($urandom_range(1, 16));
         send_request(hcbp_pkg::FUNC_LOAD, 8'($urandom_range(0, 255)),
                      16'($urandom_range(0, 65535)), length);
         requests_done++;
      end else if (pick < 88) begin
         sym = loaded_syms[$urandom_range(0, loaded_syms.size() - 1)];
         send_request(hcbp_pkg::FUNC_ENCODE, sym, 16'($urandom_range(0, 65535)),
                      5'($urandom_range(0, 31)));
         requests_done++;
      end else if (pick < 97) begin
         send_request(hcbp_pkg::FUNC_FLUSH, 8'($urandom_range(0, 255)),
                      16'($urandom_range(0, 65535)), 5'($urandom_range(0, 31)));
         requests_done++;
      end else begin
         send_request(FUNC_UNUSED, 8'($urandom_range(0, 255)),
                      16'($urandom_range(0, 65535)), 5'($urandom_range(0, 31)));
      end
   endtask

   // Main sequence.
   initial begin
      for (int i = 0; i < 256; i++)
         sym_loaded[i] = 1'b0;
      req_gaps_on          = 1'b1;
      rsp_stalls_on        = 1'b1;
      requests_done        = 0;
      reset                = 1'b1;
      req_chan.valid       = 1'b0;
      req_chan.func        = hcbp_pkg::FUNC_LOAD;
      req_chan.symbol      = '0;
      req_chan.code_value  = '0;
      req_chan.code_length = '0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: field extremes, every function, clipped and zero lengths.
      send_request(hcbp_pkg::FUNC_LOAD, 8'h00, 16'hFFFF, 5'd16);
      send_request(hcbp_pkg::FUNC_LOAD, 8'hFF, 16'h0000, 5'd31);
      send_request(hcbp_pkg::FUNC_LOAD, 8'hA5, 16'h0005, 5'd3);
      send_request(hcbp_pkg::FUNC_LOAD, 8'h5A, 16'hABCD, 5'd0);
      send_request(hcbp_pkg::FUNC_LOAD, 8'h01, 16'h0001, 5'd1);
      send_request(FUNC_UNUSED, 8'h00, 16'hFFFF, 5'd31);
      send_request(hcbp_pkg::FUNC_FLUSH, 8'h00, 16'h0000, 5'd0);
      send_request(hcbp_pkg::FUNC_ENCODE, 8'h5A, 16'h0000, 5'd0);
      send_request(hcbp_pkg::FUNC_ENCODE, 8'h00, 16'h0000, 5'd0);
      send_request(hcbp_pkg::FUNC_ENCODE, 8'hFF, 16'h0000, 5'd0);
      send_request(hcbp_pkg::FUNC_ENCODE, 8'hA5, 16'h0000, 5'd0);
      send_request(hcbp_pkg::FUNC_ENCODE, 8'h01, 16'h0000, 5'd0);
      send_request(hcbp_pkg::FUNC_FLUSH, 8'hFF, 16'hFFFF, 5'd31);
      // A load directly followed by an encode of the same symbol.
      send_request(hcbp_pkg::FUNC_LOAD, 8'hA5, 16'h007F, 5'd7);
      send_request(hcbp_pkg::FUNC_ENCODE, 8'hA5, 16'h0000, 5'd0);
      send_request(hcbp_pkg::FUNC_ENCODE, 8'h01, 16'h0000, 5'd0);
      // Exactly one full byte, so the flush has no data but a count.
      send_request(hcbp_pkg::FUNC_FLUSH, 8'h00, 16'h0000, 5'd0);
      send_request(hcbp_pkg::FUNC_LOAD, 8'h80, 16'h1234, 5'd17);
      send_request(hcbp_pkg::FUNC_ENCODE, 8'h80, 16'h0000, 5'd0);
      send_request(hcbp_pkg::FUNC_FLUSH, 8'h00, 16'h0000, 5'd0);
      wait_for_drain();

      // Random traffic, with a full drain now and then and no idling at the end.
      while (requests_done < RANDOM_REQUESTS) begin
         random_request();
         if (requests_done % DRAIN_EVERY == 0)
            wait_for_drain();
         if (requests_done >= QUIET_FROM) begin
            req_gaps_on   = 1'b0;
            rsp_stalls_on = 1'b0;
         end
      end
      send_request(hcbp_pkg::FUNC_FLUSH, 8'h00, 16'h0000, 5'd0);

      wait_for_drain();
      repeat (16) @(posedge clock);
      if (board.mismatches == 0 && board.expected_bytes.size() == 0)
         $display("** huffman_code_bit_packer: PASSED **");
      else
         $display("** huffman_code_bit_packer: FAILED **");
      $finish;
   end

endmodule
